// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// File: rtl/hsv_conv_pkg.sv
// ----------------------------------------------------------------------------
// HSV converter package
// Output field widths and the flag bundle that travels with each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsv_conv_pkg;

   localparam int HUE_W = 15;
   localparam int SAT_W = 8;
   localparam int VAL_W = 8;

   typedef struct packed {
      logic gray;
      logic wrap;
   } pix_flags_type;

endpackage

// File: rtl/hsv_conv_prep.sv
// ----------------------------------------------------------------------------
// HSV converter front end
// Finds max, min and hue sector, then forms both dividends and divisors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_conv_prep import hsv_conv_pkg::*; #(
   parameter int CHANNEL_BITS      = 8,
   parameter int HUE_FRACTION_BITS = 6,
   parameter int HQB               = 15,
   parameter int SQB               = 8,
   parameter int DW                = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [CHANNEL_BITS-1:0] red,
   input  logic [CHANNEL_BITS-1:0] green,
   input  logic [CHANNEL_BITS-1:0] blue,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [DW-1:0]           out_hue_rem,
   output logic [HQB-1:0]          out_hue_nq,
   output logic [DW-1:0]           out_hue_div,
   output logic [DW-1:0]           out_sat_rem,
   output logic [SQB-1:0]          out_sat_nq,
   output logic [DW-1:0]           out_sat_div,
   output logic [CHANNEL_BITS-1:0] out_value,
   output pix_flags_type           out_flags
);

   localparam int NB    = CHANNEL_BITS + 3;
   localparam int HNW   = HQB + DW;
   localparam int SNW   = SQB + DW;
   localparam int SIXTH = 60 * (2 ** HUE_FRACTION_BITS);
   localparam int CMAX  = (2 ** CHANNEL_BITS) - 1;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   sector_type              sector;
   logic [CHANNEL_BITS-1:0] mx_in, mn_in, delta_in;
   logic [NB-1:0]           n_in, d_ext;
   pix_flags_type           flags_in;

   logic                    v1_ff, v2_ff, ready1, ready2;
   logic [CHANNEL_BITS-1:0] mx1_ff, delta1_ff;
   logic [NB-1:0]           n1_ff;
   pix_flags_type           flags1_ff;

   logic [HNW-1:0]          hue_num;
   logic [SNW-1:0]          sat_num;

   always_comb begin
      if (red >= green && red >= blue) begin
         sector = SECT_RED;
      end else if (green >= blue) begin
         sector = SECT_GREEN;
      end else begin
         sector = SECT_BLUE;
      end
   end

   always_comb begin
      mn_in = red;
      if (green < mn_in) begin
         mn_in = green;
      end
      if (blue < mn_in) begin
         mn_in = blue;
      end
   end

   always_comb begin
      case (sector)
         SECT_RED:   mx_in = red;
         SECT_GREEN: mx_in = green;
         SECT_BLUE:  mx_in = blue;
         default:    mx_in = blue;
      endcase
   end

   assign delta_in = mx_in - mn_in;
   assign d_ext    = NB'(delta_in);

   // Negative red-sector hues are lifted by a full circle here.
   always_comb begin
      flags_in.gray = (delta_in == '0);
      flags_in.wrap = 1'b0;
      case (sector)
         SECT_RED: begin
            if (green >= blue) begin
               n_in = NB'(green) - NB'(blue);
            end else begin
               n_in = (d_ext << 2) + (d_ext << 1) + NB'(green) - NB'(blue);
               flags_in.wrap = 1'b1;
            end
         end
         SECT_GREEN: n_in = (d_ext << 1) + NB'(blue) - NB'(red);
         SECT_BLUE:  n_in = (d_ext << 2) + NB'(red) - NB'(green);
         default:    n_in = '0;
      endcase
   end

   assign ready2   = !v2_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         mx1_ff    <= mx_in;
         delta1_ff <= delta_in;
         n1_ff     <= n_in;
         flags1_ff <= flags_in;
      end
   end

   assign hue_num = HNW'(2 * SIXTH) * HNW'(n1_ff) + HNW'(delta1_ff);
   assign sat_num = SNW'(2 * CMAX) * SNW'(delta1_ff) + SNW'(mx1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && v1_ff) begin
         out_hue_rem <= hue_num[HNW-1:HQB];
         out_hue_nq  <= hue_num[HQB-1:0];
         out_hue_div <= {delta1_ff, 1'b0};
         out_sat_rem <= sat_num[SNW-1:SQB];
         out_sat_nq  <= sat_num[SQB-1:0];
         out_sat_div <= {mx1_ff, 1'b0};
         out_value   <= mx1_ff;
         out_flags   <= flags1_ff;
      end
   end

   assign out_valid = v2_ff;

endmodule

// File: rtl/hsv_conv_cell.sv
// ----------------------------------------------------------------------------
// HSV converter divider cell
// One restoring division step each for hue and saturation, where enabled by HUE_STEP and SAT_STEP, then a register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_conv_cell import hsv_conv_pkg::*; #(
   parameter int CHANNEL_BITS = 8,
   parameter int HQB          = 15,
   parameter int SQB          = 8,
   parameter int DW           = 9,
   parameter bit HUE_STEP     = 1'b1,
   parameter bit SAT_STEP     = 1'b1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [DW-1:0]           in_hue_rem,
   input  logic [HQB-1:0]          in_hue_nq,
   input  logic [DW-1:0]           in_hue_div,
   input  logic [DW-1:0]           in_sat_rem,
   input  logic [SQB-1:0]          in_sat_nq,
   input  logic [DW-1:0]           in_sat_div,
   input  logic [CHANNEL_BITS-1:0] in_value,
   input  pix_flags_type           in_flags,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [DW-1:0]           out_hue_rem,
   output logic [HQB-1:0]          out_hue_nq,
   output logic [DW-1:0]           out_hue_div,
   output logic [DW-1:0]           out_sat_rem,
   output logic [SQB-1:0]          out_sat_nq,
   output logic [DW-1:0]           out_sat_div,
   output logic [CHANNEL_BITS-1:0] out_value,
   output pix_flags_type           out_flags
);

   logic                    valid_ff;
   logic [DW:0]             hue_t, sat_t;
   logic                    hue_ge, sat_ge;
   logic [DW-1:0]           hue_rem_in, sat_rem_in;
   logic [HQB-1:0]          hue_nq_in;
   logic [SQB-1:0]          sat_nq_in;
   logic [DW-1:0]           hue_rem_ff, hue_div_ff, sat_rem_ff, sat_div_ff;
   logic [HQB-1:0]          hue_nq_ff;
   logic [SQB-1:0]          sat_nq_ff;
   logic [CHANNEL_BITS-1:0] value_ff;
   pix_flags_type           flags_ff;

   assign hue_t  = {in_hue_rem, in_hue_nq[HQB-1]};
   assign sat_t  = {in_sat_rem, in_sat_nq[SQB-1]};
   assign hue_ge = (hue_t >= {1'b0, in_hue_div});
   assign sat_ge = (sat_t >= {1'b0, in_sat_div});

   always_comb begin
      if (HUE_STEP) begin
         hue_rem_in = hue_ge ? DW'(hue_t - {1'b0, in_hue_div}) : hue_t[DW-1:0];
         hue_nq_in  = {in_hue_nq[HQB-2:0], hue_ge};
      end else begin
         hue_rem_in = in_hue_rem;
         hue_nq_in  = in_hue_nq;
      end
   end

   always_comb begin
      if (SAT_STEP) begin
         sat_rem_in = sat_ge ? DW'(sat_t - {1'b0, in_sat_div}) : sat_t[DW-1:0];
         sat_nq_in  = {in_sat_nq[SQB-2:0], sat_ge};
      end else begin
         sat_rem_in = in_sat_rem;
         sat_nq_in  = in_sat_nq;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hue_rem_ff <= hue_rem_in;
         hue_nq_ff  <= hue_nq_in;
         hue_div_ff <= in_hue_div;
         sat_rem_ff <= sat_rem_in;
         sat_nq_ff  <= sat_nq_in;
         sat_div_ff <= in_sat_div;
         value_ff   <= in_value;
         flags_ff   <= in_flags;
      end
   end

   assign out_valid   = valid_ff;
   assign out_hue_rem = hue_rem_ff;
   assign out_hue_nq  = hue_nq_ff;
   assign out_hue_div = hue_div_ff;
   assign out_sat_rem = sat_rem_ff;
   assign out_sat_nq  = sat_nq_ff;
   assign out_sat_div = sat_div_ff;
   assign out_value   = value_ff;
   assign out_flags   = flags_ff;

endmodule

// File: rtl/rgb_to_hsv_converter_core.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter core
// Converts one RGB pixel per cycle into hue, saturation, value and gray flag, unless the receiver stalls.
// ----------------------------------------------------------------------------
// Usage:
// A request carries one pixel on req_red_in, req_green_in and req_blue_in and
// is taken when req_valid and req_ready are both high. Each request yields
// exactly one response on the rsp_ channel, taken on rsp_valid and rsp_ready.
// Hue is in 1/64 degree steps, saturation and value are 8-bit fractions.
// The pipeline is two front-end stages, one divider cell per bit of the
// longer quotient (hue quotient bits or CHANNEL_BITS), and the output register.
// Throughput is one pixel per cycle while the receiver does not stall. The
// divider cells are all registered, so each cell can hold a different pixel.
// When the receiver stalls, finished results stay in the output register and
// the pipeline keeps filling its empty stages; req_ready falls only once
// every stage holds a pixel.
// A synchronous reset empties all stages; no result is shown after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_hsv_converter_core import hsv_conv_pkg::*; #(
   parameter int CHANNEL_BITS      = 8,
   parameter int HUE_FRACTION_BITS = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CHANNEL_BITS-1:0] req_red_in,
   input  logic [CHANNEL_BITS-1:0] req_green_in,
   input  logic [CHANNEL_BITS-1:0] req_blue_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [HUE_W-1:0]        rsp_hue_angle,
   output logic [SAT_W-1:0]        rsp_saturation_level,
   output logic [VAL_W-1:0]        rsp_brightness_level,
   output logic                    rsp_gray_flag
);

   localparam int SIXTH  = 60 * (2 ** HUE_FRACTION_BITS);
   localparam int FULL   = 6 * SIXTH;
   localparam int HQB    = $clog2(FULL + 1);
   localparam int SQB    = CHANNEL_BITS;
   localparam int DW     = CHANNEL_BITS + 1;
   localparam int NCELLS = (HQB > SQB) ? HQB : SQB;

   logic                    valid_w     [NCELLS+1];
   logic                    ready_w     [NCELLS+1];
   logic [DW-1:0]           hue_rem_w   [NCELLS+1];
   logic [HQB-1:0]          hue_nq_w    [NCELLS+1];
   logic [DW-1:0]           hue_div_w   [NCELLS+1];
   logic [DW-1:0]           sat_rem_w   [NCELLS+1];
   logic [SQB-1:0]          sat_nq_w    [NCELLS+1];
   logic [DW-1:0]           sat_div_w   [NCELLS+1];
   logic [CHANNEL_BITS-1:0] value_w     [NCELLS+1];
   pix_flags_type           flags_w     [NCELLS+1];

   logic                    out_ready;
   logic                    rsp_valid_ff;
   logic [HUE_W-1:0]        hue_ff, hue_in;
   logic [SAT_W-1:0]        sat_ff, sat_in;
   logic [VAL_W-1:0]        val_ff;
   logic                    gray_ff;
   logic [HQB-1:0]          hue_q;

   hsv_conv_prep #(
      .CHANNEL_BITS      (CHANNEL_BITS),
      .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
      .HQB               (HQB),
      .SQB               (SQB),
      .DW                (DW)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .red         (req_red_in),
      .green       (req_green_in),
      .blue        (req_blue_in),
      .out_valid   (valid_w[0]),
      .out_ready   (ready_w[0]),
      .out_hue_rem (hue_rem_w[0]),
      .out_hue_nq  (hue_nq_w[0]),
      .out_hue_div (hue_div_w[0]),
      .out_sat_rem (sat_rem_w[0]),
      .out_sat_nq  (sat_nq_w[0]),
      .out_sat_div (sat_div_w[0]),
      .out_value   (value_w[0]),
      .out_flags   (flags_w[0])
   );

   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      hsv_conv_cell #(
         .CHANNEL_BITS (CHANNEL_BITS),
         .HQB          (HQB),
         .SQB          (SQB),
         .DW           (DW),
         .HUE_STEP     (i >= NCELLS - HQB),
         .SAT_STEP     (i >= NCELLS - SQB)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (valid_w[i]),
         .in_ready    (ready_w[i]),
         .in_hue_rem  (hue_rem_w[i]),
         .in_hue_nq   (hue_nq_w[i]),
         .in_hue_div  (hue_div_w[i]),
         .in_sat_rem  (sat_rem_w[i]),
         .in_sat_nq   (sat_nq_w[i]),
         .in_sat_div  (sat_div_w[i]),
         .in_value    (value_w[i]),
         .in_flags    (flags_w[i]),
         .out_valid   (valid_w[i+1]),
         .out_ready   (ready_w[i+1]),
         .out_hue_rem (hue_rem_w[i+1]),
         .out_hue_nq  (hue_nq_w[i+1]),
         .out_hue_div (hue_div_w[i+1]),
         .out_sat_rem (sat_rem_w[i+1]),
         .out_sat_nq  (sat_nq_w[i+1]),
         .out_sat_div (sat_div_w[i+1]),
         .out_value   (value_w[i+1]),
         .out_flags   (flags_w[i+1])
      );
   end

   assign out_ready       = !rsp_valid_ff || rsp_ready;
   assign ready_w[NCELLS] = out_ready;
   assign hue_q           = hue_nq_w[NCELLS];

   // A lifted hue that rounds to a full circle was really zero.
   always_comb begin
      if (flags_w[NCELLS].gray ||
          (flags_w[NCELLS].wrap && hue_q == HQB'(FULL))) begin
         hue_in = '0;
      end else begin
         hue_in = HUE_W'(hue_q);
      end
      if (flags_w[NCELLS].gray) begin
         sat_in = '0;
      end else begin
         sat_in = SAT_W'(sat_nq_w[NCELLS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= valid_w[NCELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && valid_w[NCELLS]) begin
         hue_ff  <= hue_in;
         sat_ff  <= sat_in;
         val_ff  <= VAL_W'(value_w[NCELLS]);
         gray_ff <= flags_w[NCELLS].gray;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hue_angle        = hue_ff;
   assign rsp_saturation_level = sat_ff;
   assign rsp_brightness_level = val_ff;
   assign rsp_gray_flag        = gray_ff;

endmodule

// File: rtl/hsv_conv_checker.sv
// ----------------------------------------------------------------------------
// HSV converter port checker
// Watches the converter ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsv_conv_assertions import hsv_conv_pkg::*; #(
   parameter int CHANNEL_BITS      = 8,
   parameter int HUE_FRACTION_BITS = 6
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [HUE_W-1:0]        rsp_hue_angle,
   input logic [SAT_W-1:0]        rsp_saturation_level,
   input logic [VAL_W-1:0]        rsp_brightness_level,
   input logic                    rsp_gray_flag
);

   localparam longint FULL = 360 * (2 ** HUE_FRACTION_BITS);

   logic [HUE_W:0] hue_ext;

   assign hue_ext = {1'b0, rsp_hue_angle};

   `ASSERT_NEXT_ALWAYS(reset_empties_output, clock, reset, !rsp_valid)

   `ASSERT_NEXT(stalled_result_holds, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_hue_angle) && $stable(rsp_saturation_level) &&
      $stable(rsp_brightness_level) && $stable(rsp_gray_flag))

   `ASSERT_IMPLIES(gray_zeroes_hue_sat, clock, reset, rsp_valid && rsp_gray_flag,
      rsp_hue_angle == '0 && rsp_saturation_level == '0)

   `ASSERT_IMPLIES(hue_below_circle, clock, reset, rsp_valid, hue_ext < FULL)

   `ASSERT_IMPLIES(empty_output_takes_request, clock, reset, !rsp_valid, req_ready)

endmodule

bind rgb_to_hsv_converter_core hsv_conv_assertions #(
   .CHANNEL_BITS      (CHANNEL_BITS),
   .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
) u_hsv_conv_assertions (.*);
